>>> rtl/pcmfcm_pkg.sv
// Package for the PCM format converter and channel mixer.
// Holds the format, mix-mode and register codes plus fixed widths and constants.
// No dependencies; used by pcm_format_and_channel_mixer.
package pcmfcm_pkg;

    localparam int MAX_CHANNELS = 6;
    localparam int NUM_CH       = 6;

    localparam int RAW_W  = 32;
    localparam int PCM_W  = 16;
    localparam int CNT_W  = 3;
    localparam int SUM_W  = 19;   // five 16-bit samples
    localparam int MAG_W  = 18;   // magnitude of a SUM_W value
    localparam int RCP_W  = 25;
    localparam int RCP_SH = 24;
    localparam int PROD_W = MAG_W + RCP_W;

    localparam logic signed [RAW_W-1:0] FLOAT_HIGH = 32'sh43c07fff;
    localparam logic signed [RAW_W-1:0] FLOAT_LOW  = 32'sh43bf8000;
    localparam logic signed [RAW_W-1:0] FLOAT_BIAS = 32'sh43c00000;

    // Limit on channel counts: MAX_CHANNELS, at most NUM_CH, at least 1
    localparam int CH_LIMIT_A = (MAX_CHANNELS > NUM_CH) ? NUM_CH : MAX_CHANNELS;
    localparam int CH_LIMIT   = (CH_LIMIT_A < 1) ? 1 : CH_LIMIT_A;

    typedef enum logic [2:0] {
        FMT_S16LE = 3'd0,
        FMT_S16BE = 3'd1,
        FMT_U16LE = 3'd2,
        FMT_U16BE = 3'd3,
        FMT_U8    = 3'd4,
        FMT_S8    = 3'd5,
        FMT_FLOAT = 3'd6
    } fmt_t;

    typedef enum logic [2:0] {
        MODE_COPY   = 3'd0,
        MODE_DUP    = 3'd1,
        MODE_STEREO = 3'd2,
        MODE_MONO   = 3'd3,
        MODE_ZERO   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REG_SOURCE_FORMAT   = 2'd0,
        REG_SOURCE_CHANNELS = 2'd1,
        REG_DEST_CHANNELS   = 2'd2
    } reg_idx_t;

    localparam logic [CNT_W-1:0] DIV_1 = 3'd1;
    localparam logic [CNT_W-1:0] DIV_2 = 3'd2;
    localparam logic [CNT_W-1:0] DIV_3 = 3'd3;

    // ceil(2^RCP_SH / d); exact quotient for every magnitude below 2^MAG_W
    function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] d);
        logic [RCP_W-1:0] m;
        unique case (d)
            3'd2:    m = 25'd8388608;
            3'd3:    m = 25'd5592406;
            3'd4:    m = 25'd4194304;
            3'd5:    m = 25'd3355444;
            default: m = 25'd16777216;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/pcm_format_and_channel_mixer.sv
// PCM format converter and channel mixer, top level.
// Four-stage pipeline: convert, mix sums, reciprocal multiply, finish and saturate.
// Depends on pcmfcm_pkg.
//
//  channel   handshake                     payload
//  -------   ---------------------------   ------------------------------------
//  input     start, busy                   raw_ch0..raw_ch5, frame_last
//  result    done (one-cycle strobe)       pcm_ch0..pcm_ch5, frame_end
//  config    cfg_valid, cfg_ready          cfg_index, cfg_data
//
//  An item is taken on any cycle; busy stays low and one item enters per cycle.
//  Its result shows on done after the four register stages, and the divide by
//  2, 3, 4 or 5 is a multiply in the third stage.
//  Reset clears valid bits and loads format s16le with two channels in and out.
//  The receiver cannot stall, so the pipeline never holds.
module pcm_format_and_channel_mixer (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch0,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch1,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch2,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch3,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch4,
    input  logic [pcmfcm_pkg::RAW_W-1:0]           raw_ch5,
    input  logic                                   frame_last,
    output logic                                   done,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch0,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch1,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch2,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch3,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch4,
    output logic signed [pcmfcm_pkg::PCM_W-1:0]    pcm_ch5,
    output logic                                   frame_end,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [pcmfcm_pkg::CNT_W-1:0]           cfg_data
);

    localparam int NCH  = pcmfcm_pkg::NUM_CH;
    localparam int PW   = pcmfcm_pkg::PCM_W;
    localparam int SW   = pcmfcm_pkg::SUM_W;
    localparam int MW   = pcmfcm_pkg::MAG_W;
    localparam int PRW  = pcmfcm_pkg::PROD_W;
    localparam int CW   = pcmfcm_pkg::CNT_W;
    localparam int SH   = pcmfcm_pkg::RCP_SH;
    localparam int QW   = PRW - SH;

    // ---------------- configuration registers ----------------
    logic [CW-1:0] source_format_reg;
    logic [CW-1:0] source_channels_reg;
    logic [CW-1:0] dest_channels_reg;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg   <= CW'(pcmfcm_pkg::FMT_S16LE);
            source_channels_reg <= 3'd2;
            dest_channels_reg   <= 3'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pcmfcm_pkg::REG_SOURCE_FORMAT:   source_format_reg   <= cfg_data;
                pcmfcm_pkg::REG_SOURCE_CHANNELS: source_channels_reg <= cfg_data;
                pcmfcm_pkg::REG_DEST_CHANNELS:   dest_channels_reg   <= cfg_data;
                default:                         ;
            endcase
        end
    end

    // ---------------- helpers ----------------
    function automatic logic [CW-1:0] clamp_chans(input logic [CW-1:0] n);
        logic [CW-1:0] r;
        r = n;
        if (r == '0)
            r = CW'(1);
        if (int'(r) > pcmfcm_pkg::CH_LIMIT)
            r = CW'(pcmfcm_pkg::CH_LIMIT);
        return r;
    endfunction

    function automatic logic signed [PW-1:0] convert_one(
        input logic [CW-1:0]                 fmt,
        input logic [pcmfcm_pkg::RAW_W-1:0]  w
    );
        logic signed [PW-1:0] r;
        logic [PW-1:0]        sw;
        logic signed [pcmfcm_pkg::RAW_W-1:0] v;
        sw = {w[7:0], w[15:8]};
        v  = $signed(w);
        unique case (fmt)
            pcmfcm_pkg::FMT_S16LE: r = $signed(w[15:0]);
            pcmfcm_pkg::FMT_S16BE: r = $signed(sw);
            pcmfcm_pkg::FMT_U16LE: r = $signed({~w[15], w[14:0]});
            pcmfcm_pkg::FMT_U16BE: r = $signed({~sw[15], sw[14:0]});
            pcmfcm_pkg::FMT_U8:    r = $signed({~w[7], w[6:0], 8'h00});
            pcmfcm_pkg::FMT_S8:    r = $signed({w[7:0], 8'h00});
            pcmfcm_pkg::FMT_FLOAT:
            begin
                if (v > pcmfcm_pkg::FLOAT_HIGH)
                    r = 16'sh7fff;
                else if (v < pcmfcm_pkg::FLOAT_LOW)
                    r = -16'sh8000;
                else
                    r = PW'(v - pcmfcm_pkg::FLOAT_BIAS);
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [PW-1:0] sat16(input logic signed [QW:0] x);
        logic signed [PW-1:0] r;
        if (x > (QW+1)'(32767))
            r = 16'sh7fff;
        else if (x < -(QW+1)'(32768))
            r = -16'sh8000;
        else
            r = PW'(x);
        return r;
    endfunction

    // ---------------- stage 1: convert and pick the mix mode ----------------
    logic [pcmfcm_pkg::RAW_W-1:0] raw [NCH];
    assign raw[0] = raw_ch0;
    assign raw[1] = raw_ch1;
    assign raw[2] = raw_ch2;
    assign raw[3] = raw_ch3;
    assign raw[4] = raw_ch4;
    assign raw[5] = raw_ch5;

    logic [CW-1:0]          src_cnt;
    logic [CW-1:0]          dst_cnt;
    pcmfcm_pkg::mode_t      mode_next;
    logic signed [PW-1:0]   smp_next [NCH];

    logic                   v1_reg;
    logic                   last1_reg;
    logic signed [PW-1:0]   smp1_reg [NCH];
    pcmfcm_pkg::mode_t      mode1_reg;
    logic [CW-1:0]          dst1_reg;
    logic                   div3_1_reg;
    logic [CW-1:0]          n1_reg;

    assign src_cnt = clamp_chans(source_channels_reg);
    assign dst_cnt = clamp_chans(dest_channels_reg);

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
            smp_next[i] = (i < int'(src_cnt)) ? convert_one(source_format_reg, raw[i]) : '0;

        if (src_cnt == dst_cnt)
            mode_next = pcmfcm_pkg::MODE_COPY;
        else if (src_cnt > dst_cnt)
        begin
            priority if (dst_cnt == 3'd4 || dst_cnt == 3'd5)
                mode_next = pcmfcm_pkg::MODE_COPY;
            else if (dst_cnt == 3'd2)
                mode_next = pcmfcm_pkg::MODE_STEREO;
            else if (dst_cnt == 3'd1)
                mode_next = pcmfcm_pkg::MODE_MONO;
            else
                mode_next = pcmfcm_pkg::MODE_ZERO;
        end
        else if (src_cnt == 3'd1)
            mode_next = pcmfcm_pkg::MODE_DUP;
        else
            mode_next = pcmfcm_pkg::MODE_COPY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        last1_reg  <= frame_last;
        smp1_reg   <= smp_next;
        mode1_reg  <= mode_next;
        dst1_reg   <= dst_cnt;
        div3_1_reg <= (src_cnt > 3'd4);
        n1_reg     <= (src_cnt > 3'd5) ? 3'd5 : src_cnt;
    end

    // ---------------- stage 2: mix sums and divisors ----------------
    logic signed [SW-1:0]   pre_next [NCH];
    logic [CW-1:0]          d0_next;
    logic [CW-1:0]          d1_next;
    logic signed [SW-1:0]   s4_term;

    logic                   v2_reg;
    logic                   last2_reg;
    logic signed [SW-1:0]   pre2_reg [NCH];
    logic [CW-1:0]          d0_2_reg;
    logic [CW-1:0]          d1_2_reg;
    pcmfcm_pkg::mode_t      mode2_reg;

    assign s4_term = div3_1_reg ? SW'(smp1_reg[4]) : '0;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
            pre_next[i] = '0;
        d0_next = pcmfcm_pkg::DIV_1;
        d1_next = pcmfcm_pkg::DIV_1;
        unique case (mode1_reg)
            pcmfcm_pkg::MODE_COPY:
            begin
                for (int i = 0; i < NCH; i++)
                    pre_next[i] = (i < int'(dst1_reg)) ? SW'(smp1_reg[i]) : '0;
            end
            pcmfcm_pkg::MODE_DUP:
            begin
                for (int i = 0; i < NCH; i++)
                    pre_next[i] = (i < int'(dst1_reg)) ? SW'(smp1_reg[i]) : '0;
                pre_next[1] = SW'(smp1_reg[0]);
            end
            pcmfcm_pkg::MODE_STEREO:
            begin
                pre_next[0] = SW'(smp1_reg[0]) + SW'(smp1_reg[2]) + s4_term;
                pre_next[1] = SW'(smp1_reg[1]) + SW'(smp1_reg[3]) + s4_term;
                d0_next     = div3_1_reg ? pcmfcm_pkg::DIV_3 : pcmfcm_pkg::DIV_2;
                d1_next     = d0_next;
            end
            pcmfcm_pkg::MODE_MONO:
            begin
                // absent channels are already zero, so sum all five
                pre_next[0] = SW'(smp1_reg[0]) + SW'(smp1_reg[1]) + SW'(smp1_reg[2])
                            + SW'(smp1_reg[3]) + SW'(smp1_reg[4]);
                d0_next     = n1_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        last2_reg <= last1_reg;
        pre2_reg  <= pre_next;
        d0_2_reg  <= d0_next;
        d1_2_reg  <= d1_next;
        mode2_reg <= mode1_reg;
    end

    // ---------------- stage 3: magnitude times reciprocal ----------------
    logic [MW-1:0]          mag0;
    logic [MW-1:0]          mag1;

    logic                   v3_reg;
    logic                   last3_reg;
    logic [PRW-1:0]         prod0_3_reg;
    logic [PRW-1:0]         prod1_3_reg;
    logic                   neg0_3_reg;
    logic                   neg1_3_reg;
    logic signed [PW-1:0]   hi3_reg [2:NCH-1];
    pcmfcm_pkg::mode_t      mode3_reg;

    assign mag0 = pre2_reg[0][SW-1] ? MW'(-pre2_reg[0]) : MW'(pre2_reg[0]);
    assign mag1 = pre2_reg[1][SW-1] ? MW'(-pre2_reg[1]) : MW'(pre2_reg[1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        last3_reg   <= last2_reg;
        prod0_3_reg <= PRW'(mag0) * PRW'(pcmfcm_pkg::recip(d0_2_reg));
        prod1_3_reg <= PRW'(mag1) * PRW'(pcmfcm_pkg::recip(d1_2_reg));
        neg0_3_reg  <= pre2_reg[0][SW-1];
        neg1_3_reg  <= pre2_reg[1][SW-1];
        for (int i = 2; i < NCH; i++)
            hi3_reg[i] <= PW'(pre2_reg[i]);
        mode3_reg   <= mode2_reg;
    end

    // ---------------- stage 4: quotient, sign, saturate ----------------
    logic [QW-1:0]          q0;
    logic [QW-1:0]          q1;
    logic signed [QW:0]     val0;
    logic signed [QW:0]     val1;

    logic                   done_reg;
    logic                   frame_end_reg;
    logic signed [PW-1:0]   pcm_reg [NCH];

    assign q0   = prod0_3_reg[PRW-1:SH];
    assign q1   = prod1_3_reg[PRW-1:SH];
    assign val0 = neg0_3_reg ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
    assign val1 = neg1_3_reg ? -$signed({1'b0, q1}) : $signed({1'b0, q1});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        frame_end_reg <= last3_reg;
        pcm_reg[0]    <= sat16(val0);
        pcm_reg[1]    <= sat16(val1);
        for (int i = 2; i < NCH; i++)
            pcm_reg[i] <= hi3_reg[i];
    end

    assign done      = done_reg;
    assign frame_end = frame_end_reg;
    assign pcm_ch0   = pcm_reg[0];
    assign pcm_ch1   = pcm_reg[1];
    assign pcm_ch2   = pcm_reg[2];
    assign pcm_ch3   = pcm_reg[3];
    assign pcm_ch4   = pcm_reg[4];
    assign pcm_ch5   = pcm_reg[5];

    // ---------------- assertions ----------------
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted item produced no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result without an accepted item");

    a_last_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 (frame_end == $past(frame_last, 4)))
        else $error("frame_end does not match its item");

    a_fold_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (mode3_reg != pcmfcm_pkg::MODE_COPY)
                && (mode3_reg != pcmfcm_pkg::MODE_DUP))
        |=> (pcm_ch2 == '0 && pcm_ch3 == '0 && pcm_ch4 == '0 && pcm_ch5 == '0))
        else $error("upper channels not cleared in fold or mono mix");

endmodule

>>> tb/pcm_format_and_channel_mixer_test.sv
// Self-checking testbench for pcm_format_and_channel_mixer: directed rows, then random
// format and channel-map phases, each result frame checked against its table row or a local predictor.
// Depends on pcmfcm_pkg and the pcm_format_and_channel_mixer RTL.
module pcm_format_and_channel_mixer_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY      = 4;
    localparam int DRAIN_PAD    = LATENCY + 2;
    localparam int RANDOM_ITEMS = 1200;

    localparam int CLAMP_HI_WORD = 32'sh43c0_7fff;
    localparam int CLAMP_LO_WORD = 32'sh43bf_8000;
    localparam int ZERO_WORD     = 32'sh43c0_0000;

    localparam logic [2:0]  FMT_UNDEFINED = 3'd7;
    localparam bit          KNOWN         = 1'b1;
    localparam bit          PREDICTED     = 1'b0;
    localparam logic [31:0] ALL_ONES      = 32'hffff_ffff;

    localparam logic [5:0][31:0] RAW_MIX = {32'h0000_fff9, 32'h1111_0007, 32'h0000_fedb,
                                            32'hffff_1235, 32'h0000_7fff, 32'h0000_8000};
    localparam logic [5:0][31:0] RAW_MAX = {6{32'h0000_7fff}};
    localparam logic [5:0][31:0] RAW_MIN = {6{32'hffff_8000}};
    localparam logic [5:0][15:0] NO_PCM  = '0;

    typedef struct packed {
        logic [5:0][15:0] ch;
        logic             last;
    } pcm_frame_t;

    typedef struct packed {
        logic [2:0]       fmt;
        logic [2:0]       src;
        logic [2:0]       dst;
        logic [5:0][31:0] raw;
        logic             last;
        logic             known;
        logic [5:0][15:0] pcm;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic [pcmfcm_pkg::RAW_W-1:0]        raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_ch4, raw_ch5;
    logic                                frame_last;
    logic                                done;
    logic signed [pcmfcm_pkg::PCM_W-1:0] pcm_ch0, pcm_ch1, pcm_ch2, pcm_ch3, pcm_ch4, pcm_ch5;
    logic                                frame_end;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [1:0]                          cfg_index;
    logic [pcmfcm_pkg::CNT_W-1:0]        cfg_data;

    // Mirror of the block's registers, loaded with the reset values
    logic [2:0] fmt_reg = pcmfcm_pkg::FMT_S16LE;
    logic [2:0] src_reg = 3'd2;
    logic [2:0] dst_reg = 3'd2;

    pcm_frame_t pending_frames[$];
    int         bad_results = 0;
    bit         burst = 1'b0;

    pcm_format_and_channel_mixer i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("pcm_format_and_channel_mixer_test: FAIL");
        $finish;
    end

    function automatic int sample_to_s16(logic [31:0] w);
        int v;
        case (pcmfcm_pkg::fmt_t'(fmt_reg))
            pcmfcm_pkg::FMT_S16LE: v = $signed(w[15:0]);
            pcmfcm_pkg::FMT_S16BE: v = $signed({w[7:0], w[15:8]});
            pcmfcm_pkg::FMT_U16LE: v = {16'h0000, w[15:0]} - 32768;
            pcmfcm_pkg::FMT_U16BE: v = {16'h0000, w[7:0], w[15:8]} - 32768;
            pcmfcm_pkg::FMT_U8:    v = {16'h0000, w[7:0], 8'h00} - 32768;
            pcmfcm_pkg::FMT_S8:    v = $signed({w[7:0], 8'h00});
            pcmfcm_pkg::FMT_FLOAT:
            begin
                v = $signed(w);
                if (v > CLAMP_HI_WORD)
                    v = 32767;
                else if (v < CLAMP_LO_WORD)
                    v = -32768;
                else
                    v = v - ZERO_WORD;
            end
            default:   v = 0;
        endcase
        return v;
    endfunction

    function automatic int clamp_count(logic [2:0] n);
        if (n < 1)
            return 1;
        if (n > pcmfcm_pkg::NUM_CH)
            return pcmfcm_pkg::NUM_CH;
        return n;
    endfunction

    function automatic int saturate(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Convert every present channel, then remap to the destination channel count
    function automatic pcm_frame_t mix_frame(logic [5:0][31:0] raw, logic last);
        int s[6];
        int o[6];
        int src;
        int dst;
        int n;
        int l;
        int r;
        int sum;
        pcm_frame_t f;
        src = clamp_count(src_reg);
        dst = clamp_count(dst_reg);
        for (int i = 0; i < 6; i++)
        begin
            s[i] = (i < src) ? sample_to_s16(raw[i]) : 0;
            o[i] = 0;
        end
        if (src == dst)
        begin
            for (int i = 0; i < dst; i++)
                o[i] = s[i];
        end
        else if (src > dst)
        begin
            case (dst)
                4, 5:
                    for (int i = 0; i < dst; i++)
                        o[i] = s[i];
                2:
                begin
                    l = s[0] + s[2];
                    r = s[1] + s[3];
                    if (src > 4)
                    begin
                        l = (l + s[4]) / 3;
                        r = (r + s[4]) / 3;
                    end
                    else
                    begin
                        l = l / 2;
                        r = r / 2;
                    end
                    o[0] = saturate(l);
                    o[1] = saturate(r);
                end
                1:
                begin
                    n = (src > 5) ? 5 : src;
                    sum = 0;
                    for (int i = 0; i < n; i++)
                        sum += s[i];
                    o[0] = saturate(sum / n);
                end
                default: ;  // three from more channels is not supported: all zero
            endcase
        end
        else
        begin
            for (int i = 0; i < src; i++)
                o[i] = s[i];
            if (src == 1)
                o[1] = s[0];
        end
        for (int i = 0; i < 6; i++)
            f.ch[i] = 16'(o[i]);
        f.last = last;
        return f;
    endfunction

    function automatic stim_row_t row(logic [2:0] fmt, logic [2:0] src, logic [2:0] dst,
                                      logic [5:0][31:0] raw, logic last, logic known,
                                      logic [5:0][15:0] pcm);
        stim_row_t t;
        t.fmt   = fmt;
        t.src   = src;
        t.dst   = dst;
        t.raw   = raw;
        t.last  = last;
        t.known = known;
        t.pcm   = pcm;
        return t;
    endfunction

    function automatic logic [31:0] rand_word();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 3))
            0: ;
            1:
                case ($urandom_range(0, 7))
                    0: w[15:0] = 16'h0000;
                    1: w[15:0] = 16'hffff;
                    2: w[15:0] = 16'h7fff;
                    3: w[15:0] = 16'h8000;
                    4: w[15:0] = 16'h007f;
                    5: w[15:0] = 16'h0080;
                    6: w[15:0] = 16'hff7f;
                    default: w[15:0] = 16'h80ff;
                endcase
            default:
                // keep float words near the clamp window so both bounds get hit
                if (fmt_reg == pcmfcm_pkg::FMT_FLOAT)
                    w = 32'h43bf_0000 + $urandom_range(0, 32'h0002_0000);
        endcase
        return w;
    endfunction

    function automatic logic [2:0] rand_count();
        case ($urandom_range(0, 11))
            0:       return 3'd0;
            1:       return 3'd7;
            default: return 3'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic void report_bad(string msg);
        bad_results++;
        if (bad_results <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Wait until every pending frame has come out, then let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_frames.size() != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic write_reg(pcmfcm_pkg::reg_idx_t idx, logic [2:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            pcmfcm_pkg::REG_SOURCE_FORMAT:   fmt_reg = val;
            pcmfcm_pkg::REG_SOURCE_CHANNELS: src_reg = val;
            pcmfcm_pkg::REG_DEST_CHANNELS:   dst_reg = val;
            default: ;
        endcase
    endtask

    task automatic set_mode(logic [2:0] fmt, logic [2:0] src, logic [2:0] dst);
        if (fmt != fmt_reg)
            write_reg(pcmfcm_pkg::REG_SOURCE_FORMAT, fmt);
        if (src != src_reg)
            write_reg(pcmfcm_pkg::REG_SOURCE_CHANNELS, src);
        if (dst != dst_reg)
            write_reg(pcmfcm_pkg::REG_DEST_CHANNELS, dst);
    endtask

    task automatic send_frame(logic [5:0][31:0] raw, logic last, logic known,
                              logic [5:0][15:0] pcm);
        int gap;
        pcm_frame_t want;
        gap = burst ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        raw_ch0    <= raw[0];
        raw_ch1    <= raw[1];
        raw_ch2    <= raw[2];
        raw_ch3    <= raw[3];
        raw_ch4    <= raw[4];
        raw_ch5    <= raw[5];
        frame_last <= last;
        do
            @(posedge clk);
        while (busy);
        want = mix_frame(raw, last);
        if (known)
            want.ch = pcm;
        pending_frames.push_back(want);
    endtask

    always @(posedge clk)
    begin : result_check
        pcm_frame_t       want;
        logic [5:0][15:0] got;
        if (rst_n && done)
        begin
            got = {pcm_ch5, pcm_ch4, pcm_ch3, pcm_ch2, pcm_ch1, pcm_ch0};
            if (pending_frames.size() == 0)
                report_bad($sformatf("result with no frame pending, ch0 %0d",
                                     $signed(got[0])));
            else
            begin
                want = pending_frames.pop_front();
                for (int i = 0; i < 6; i++)
                    if (got[i] !== want.ch[i])
                        report_bad($sformatf("pcm_ch%0d expected %0d got %0d", i,
                                             $signed(want.ch[i]), $signed(got[i])));
                if (frame_end !== want.last)
                    report_bad($sformatf("frame_end expected %0b got %0b",
                                         want.last, frame_end));
            end
        end
    end

    initial
    begin
        stim_row_t        plan[$];
        logic [5:0][31:0] raw;
        logic [2:0]       fmt;
        int               sent;
        int               phase;
        int               len;
        int               hold_at;

        rst_n      <= 1'b0;
        start      <= 1'b0;
        raw_ch0    <= '0;
        raw_ch1    <= '0;
        raw_ch2    <= '0;
        raw_ch3    <= '0;
        raw_ch4    <= '0;
        raw_ch5    <= '0;
        frame_last <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= pcmfcm_pkg::REG_SOURCE_FORMAT;
        cfg_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Format extremes first, starting from the reset settings
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'habcd_8000, 32'hffff_7fff},
                           1'b1, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7fff}));
        plan.push_back(row(pcmfcm_pkg::FMT_S16BE, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'habcd_0080, 32'h0000_ff7f},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7fff}));
        plan.push_back(row(pcmfcm_pkg::FMT_U16LE, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h0000_ffff, 32'hffff_0000},
                           1'b1, KNOWN, {{4{16'h0}}, 16'h7fff, 16'h8000}));
        plan.push_back(row(pcmfcm_pkg::FMT_U16BE, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h0000_ffff, 32'h0000_0080},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h7fff, 16'h0000}));
        plan.push_back(row(pcmfcm_pkg::FMT_U8, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'hffff_ff00, 32'h0000_00ff},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7f00}));
        plan.push_back(row(pcmfcm_pkg::FMT_S8, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h0000_0080, 32'h0000_007f},
                           1'b1, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7f00}));
        plan.push_back(row(pcmfcm_pkg::FMT_FLOAT, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h43bf_8000, 32'h43c0_7fff},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7fff}));
        plan.push_back(row(pcmfcm_pkg::FMT_FLOAT, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h43bf_7fff, 32'h43c0_8000},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h8000, 16'h7fff}));
        plan.push_back(row(pcmfcm_pkg::FMT_FLOAT, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h7fff_ffff, 32'h8000_0000},
                           1'b1, KNOWN, {{4{16'h0}}, 16'h7fff, 16'h8000}));
        plan.push_back(row(pcmfcm_pkg::FMT_FLOAT, 3'd2, 3'd2,
                           {{4{ALL_ONES}}, 32'h43c0_0001, 32'h43c0_0000},
                           1'b0, KNOWN, {{4{16'h0}}, 16'h0001, 16'h0000}));
        plan.push_back(row(FMT_UNDEFINED, 3'd2, 3'd2, {6{ALL_ONES}}, 1'b1, KNOWN, NO_PCM));
        // Channel maps: folds, averages, drops, unsupported target, upmix, clamped counts
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd2, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd2, RAW_MIN, 1'b0, KNOWN,
                           {{4{16'h0}}, 16'h8000, 16'h8000}));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd5, 3'd2, RAW_MIX, 1'b1, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd4, 3'd2, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd3, 3'd2, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd1, RAW_MAX, 1'b0, KNOWN,
                           {{5{16'h0}}, 16'h7fff}));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd1, RAW_MIX, 1'b1, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd4, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd6, 3'd5, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd4, 3'd3, RAW_MIX, 1'b1, KNOWN, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd1, 3'd6, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd3, 3'd6, RAW_MIX, 1'b0, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd0, 3'd7, RAW_MIX, 1'b1, PREDICTED, NO_PCM));
        plan.push_back(row(pcmfcm_pkg::FMT_S16LE, 3'd7, 3'd0, RAW_MIX, 1'b0, PREDICTED, NO_PCM));

        foreach (plan[k])
        begin
            set_mode(plan[k].fmt, plan[k].src, plan[k].dst);
            send_frame(plan[k].raw, plan[k].last, plan[k].known, plan[k].pcm);
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                fmt = FMT_UNDEFINED;
            else
                fmt = 3'($urandom_range(0, 6));
            set_mode(fmt, rand_count(), rand_count());
            burst = ($urandom_range(0, 3) == 0);
            len = $urandom_range(10, 60);
            // hold off mid-phase until the pipeline has emptied
            hold_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(1, len - 1) : -1;
            for (int k = 0; k < len; k++)
            begin
                if (k == hold_at)
                    drain();
                for (int c = 0; c < 6; c++)
                    raw[c] = rand_word();
                send_frame(raw, 1'($urandom_range(0, 1)), PREDICTED, NO_PCM);
                sent++;
            end
            phase++;
        end

        drain();
        if (bad_results == 0)
            $display("pcm_format_and_channel_mixer_test: PASS");
        else
            $display("pcm_format_and_channel_mixer_test: FAIL");
        $finish;
    end

endmodule

>>> files.f
rtl/pcmfcm_pkg.sv
rtl/pcm_format_and_channel_mixer.sv
tb/pcm_format_and_channel_mixer_test.sv
